// ===== src/stick_to_scroll_wheel_assert.svh =====
// Assertion macros used by the checker file.
`ifndef STICK_TO_SCROLL_WHEEL_ASSERT_SVH
`define STICK_TO_SCROLL_WHEEL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: property failed");

`endif

// ===== src/ssw_pkg.sv =====
`default_nettype none

package ssw_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int GAIN_SHIFT = 23 - FRAC_BITS;
	localparam int ACC_W      = 26;
	localparam int PROD_W     = 30;
	localparam int DELTA_W    = PROD_W - GAIN_SHIFT;
	localparam int SUM_W      = 32;
	localparam int WHOLE_W    = ACC_W + 1 - FRAC_BITS;
	localparam int FINE_W     = 7;
	localparam int FINE_LIMIT = 64;
	localparam int CMP_W      = (ACC_W + 1 > 8 + FRAC_BITS) ? ACC_W + 1 : 8 + FRAC_BITS;

	localparam logic signed [SUM_W-1:0] SUM_ACC_MAX = SUM_W'(2 ** (ACC_W - 1) - 1);
	localparam logic signed [SUM_W-1:0] SUM_ACC_MIN = SUM_W'(-(2 ** (ACC_W - 1)));

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_EN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_VERT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_HORIZ = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NOTCH_UNITS  = 3'd5;

	localparam logic [2:0] KIND_VFINE  = 3'd0;
	localparam logic [2:0] KIND_HFINE  = 3'd1;
	localparam logic [2:0] KIND_VNOTCH = 3'd2;
	localparam logic [2:0] KIND_HNOTCH = 3'd3;
	localparam logic [2:0] KIND_SYNC   = 3'd4;

	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [DELTA_W-1:0] delta_t;

	typedef struct packed {
		logic [15:0] stick_vertical;
		logic [15:0] stick_horizontal;
	} tick_t;

	typedef struct packed {
		logic [2:0]        event_kind;
		logic signed [7:0] event_value;
		logic              last_event;
	} evt_t;

	typedef struct packed {
		logic [15:0] deadzone_counts;
		logic [12:0] gain_q8;
		logic        horiz_enable;
		logic        invert_vertical;
		logic        invert_horizontal;
		logic [7:0]  notch_units;
	} cfg_t;

	// One tick's worth of events. mask bits: vfine, hfine, vnotch, hnotch, sync.
	typedef struct packed {
		logic [4:0]        mask;
		logic signed [7:0] vfine;
		logic signed [7:0] hfine;
		logic              vnotch_neg;
		logic              hnotch_neg;
	} rec_t;

endpackage

`default_nettype wire

// ===== src/ssw_front.sv =====
`default_nettype none

module ssw_front (
	input  logic           clk,
	input  logic           arst_n,
	input  ssw_pkg::cfg_t  cfg,
	input  logic           tick_valid,
	output logic           tick_ready,
	input  ssw_pkg::tick_t tick,
	output logic           rec_valid,
	input  logic           rec_ready,
	output ssw_pkg::rec_t  rec
);
	import ssw_pkg::*;

	typedef struct packed {
		logic              hit;
		logic signed [7:0] value;
		acc_t              acc;
	} fine_res_t;

	typedef struct packed {
		logic hit;
		logic neg;
		acc_t acc;
	} notch_res_t;

	function automatic acc_t sat_add(acc_t a, delta_t d);
		logic signed [SUM_W-1:0] s;
		s = {{(SUM_W - ACC_W){a[ACC_W-1]}}, a} + {{(SUM_W - DELTA_W){d[DELTA_W-1]}}, d};
		if (s > SUM_ACC_MAX)
			return SUM_ACC_MAX[ACC_W-1:0];
		if (s < SUM_ACC_MIN)
			return SUM_ACC_MIN[ACC_W-1:0];
		return s[ACC_W-1:0];
	endfunction

	// Whole units truncated toward zero, limited to +-64.
	function automatic fine_res_t fine_step(acc_t a);
		fine_res_t         r;
		logic signed [ACC_W:0] ax;
		logic [ACC_W:0]    mag;
		logic [WHOLE_W-1:0] wm;
		logic [FINE_W-1:0] m;
		logic signed [7:0] v;
		acc_t              sub;
		ax  = {a[ACC_W-1], a};
		mag = a[ACC_W-1] ? -ax : ax;
		wm  = mag[ACC_W:FRAC_BITS];
		m   = (wm > WHOLE_W'(FINE_LIMIT)) ? FINE_W'(FINE_LIMIT) : wm[FINE_W-1:0];
		v   = a[ACC_W-1] ? -{1'b0, m} : {1'b0, m};
		sub = {{(ACC_W - 8){v[7]}}, v} << FRAC_BITS;
		r.hit   = (wm != '0);
		r.value = v;
		r.acc   = r.hit ? a - sub : a;
		return r;
	endfunction

	function automatic notch_res_t notch_step(acc_t a, logic [7:0] nu);
		notch_res_t        r;
		logic signed [ACC_W:0] ax;
		logic [ACC_W:0]    mag;
		logic [7:0]        nu_eff;
		logic [CMP_W-1:0]  size;
		nu_eff = (nu == 8'd0) ? 8'd1 : nu;
		size   = CMP_W'(nu_eff) << FRAC_BITS;
		ax     = {a[ACC_W-1], a};
		mag    = a[ACC_W-1] ? -ax : ax;
		r.hit  = (CMP_W'(mag) >= size);
		r.neg  = a[ACC_W-1];
		if (!r.hit)
			r.acc = a;
		else if (r.neg)
			r.acc = a + size[ACC_W-1:0];
		else
			r.acc = a - size[ACC_W-1:0];
		return r;
	endfunction

	// stage 1: raw sample
	logic        v_s1;
	logic [15:0] vert_s1, horiz_s1;
	// stage 2: scaled products
	logic                     v_s2;
	logic signed [PROD_W-1:0] pv_s2, ph_s2;

	acc_t vert_fine_q, vert_notch_q, horiz_fine_q, horiz_notch_q;

	logic signed [15:0]       off_v, off_h;
	logic signed [16:0]       offx_v, offx_h;
	logic [16:0]              mag_v, mag_h;
	logic signed [13:0]       gfac_v, gfac_h;
	logic signed [PROD_W-1:0] mv, mh, pv_d, ph_d;
	logic                     zero_v, zero_h;

	delta_t     dv, dh;
	fine_res_t  vf, hf;
	notch_res_t vn, hn;
	logic       any_evt, s2_done, s2_free;

	// offset from centre is the raw value with its top bit flipped
	assign off_v  = {~vert_s1[15], vert_s1[14:0]};
	assign off_h  = {~horiz_s1[15], horiz_s1[14:0]};
	assign offx_v = {off_v[15], off_v};
	assign offx_h = {off_h[15], off_h};
	assign mag_v  = off_v[15] ? -offx_v : offx_v;
	assign mag_h  = off_h[15] ? -offx_h : offx_h;
	assign zero_v = (mag_v < {1'b0, cfg.deadzone_counts});
	assign zero_h = (mag_h < {1'b0, cfg.deadzone_counts}) || !cfg.horiz_enable;

	// vertical is negated unless inverted; horizontal only when inverted
	assign gfac_v = cfg.invert_vertical ? $signed({1'b0, cfg.gain_q8})
	                                    : -$signed({1'b0, cfg.gain_q8});
	assign gfac_h = cfg.invert_horizontal ? -$signed({1'b0, cfg.gain_q8})
	                                      : $signed({1'b0, cfg.gain_q8});
	assign mv   = PROD_W'(off_v) * PROD_W'(gfac_v);
	assign mh   = PROD_W'(off_h) * PROD_W'(gfac_h);
	assign pv_d = zero_v ? '0 : mv;
	assign ph_d = zero_h ? '0 : mh;

	assign dv = pv_s2[PROD_W-1:GAIN_SHIFT];
	assign dh = ph_s2[PROD_W-1:GAIN_SHIFT];
	assign vf = fine_step(sat_add(vert_fine_q, dv));
	assign hf = fine_step(sat_add(horiz_fine_q, dh));
	assign vn = notch_step(sat_add(vert_notch_q, dv), cfg.notch_units);
	assign hn = notch_step(sat_add(horiz_notch_q, dh), cfg.notch_units);

	assign any_evt = vf.hit || hf.hit || vn.hit || hn.hit;
	assign rec_valid      = v_s2 && any_evt;
	assign rec.mask       = {any_evt, hn.hit, vn.hit, hf.hit, vf.hit};
	assign rec.vfine      = vf.value;
	assign rec.hfine      = hf.value;
	assign rec.vnotch_neg = vn.neg;
	assign rec.hnotch_neg = hn.neg;

	// a quiet tick retires without a queue slot
	assign s2_done    = v_s2 && (!any_evt || rec_ready);
	assign s2_free    = !v_s2 || s2_done;
	assign tick_ready = !v_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (tick_ready)
				v_s1 <= tick_valid;
			if (s2_free)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			vert_s1  <= tick.stick_vertical;
			horiz_s1 <= tick.stick_horizontal;
		end
		if (s2_free && v_s1) begin
			pv_s2 <= pv_d;
			ph_s2 <= ph_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_fine_q   <= '0;
			vert_notch_q  <= '0;
			horiz_fine_q  <= '0;
			horiz_notch_q <= '0;
		end else if (s2_done) begin
			vert_fine_q   <= vf.acc;
			vert_notch_q  <= vn.acc;
			horiz_fine_q  <= hf.acc;
			horiz_notch_q <= hn.acc;
		end
	end

endmodule

`default_nettype wire

// ===== src/ssw_queue.sv =====
`default_nettype none

module ssw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  ssw_pkg::rec_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output ssw_pkg::rec_t pop_data
);
	import ssw_pkg::*;

	rec_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != (QPTR_W + 1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

// ===== src/ssw_back.sv =====
`default_nettype none

module ssw_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rec_valid,
	output logic          rec_ready,
	input  ssw_pkg::rec_t rec,
	output logic          evt_valid,
	input  logic          evt_ready,
	output ssw_pkg::evt_t evt
);
	import ssw_pkg::*;

	rec_t       cur_q;
	logic [4:0] mask_q;
	logic       evt_valid_q;
	evt_t       evt_q;

	logic       load_out, last;
	logic [4:0] pick;
	evt_t       nxt;

	// lowest pending bit goes out first
	always_comb begin
		pick = 5'b00000;
		nxt  = '0;
		if (mask_q[0]) begin
			pick            = 5'b00001;
			nxt.event_kind  = KIND_VFINE;
			nxt.event_value = cur_q.vfine;
		end else if (mask_q[1]) begin
			pick            = 5'b00010;
			nxt.event_kind  = KIND_HFINE;
			nxt.event_value = cur_q.hfine;
		end else if (mask_q[2]) begin
			pick            = 5'b00100;
			nxt.event_kind  = KIND_VNOTCH;
			nxt.event_value = cur_q.vnotch_neg ? -8'sd1 : 8'sd1;
		end else if (mask_q[3]) begin
			pick            = 5'b01000;
			nxt.event_kind  = KIND_HNOTCH;
			nxt.event_value = cur_q.hnotch_neg ? -8'sd1 : 8'sd1;
		end else if (mask_q[4]) begin
			pick            = 5'b10000;
			nxt.event_kind  = KIND_SYNC;
			nxt.event_value = 8'sd0;
		end
		last           = pick[4];
		nxt.last_event = last;
	end

	assign load_out  = (mask_q != '0) && (!evt_valid_q || evt_ready);
	assign rec_ready = (mask_q == '0) || (load_out && last);
	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			evt_valid_q <= 1'b0;
		end else begin
			if (rec_valid && rec_ready)
				mask_q <= rec.mask;
			else if (load_out)
				mask_q <= mask_q & ~pick;
			if (load_out)
				evt_valid_q <= 1'b1;
			else if (evt_ready)
				evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid && rec_ready)
			cur_q <= rec;
		if (load_out)
			evt_q <= nxt;
	end

endmodule

`default_nettype wire

// ===== src/stick_to_scroll_wheel.sv =====
// Stick to scroll wheel converter.
// Tick channel (tick_valid/tick_ready/tick): one request per sample, carrying the
// raw 16-bit vertical and horizontal stick positions.
// Event channel (evt_valid/evt_ready/evt): per tick, in order, vertical fine,
// horizontal fine, vertical notch, horizontal notch, then sync with last_event
// set. Absent events are skipped; a quiet tick produces nothing at all.
// Config port: cfg_we writes cfg_data into register cfg_index;
// write only while no tick is in flight.
// The first event of a tick passes the sample register, the multiply register,
// the accumulate into the queue, the back-end record register and the event register.
// Throughput: the front takes one tick per cycle unless stalled; the back end sends
// one event per cycle while evt_ready is high, with no gap between ticks; a tick
// carries up to 5 events.
// A 4-deep record queue sits between the accumulators and the event serializer;
// when evt_ready is low the queue fills, then the front stalls and tick_ready drops.
// Reset clears all accumulators, the pipeline and the queue, and loads the
// register defaults (deadzone 655, gain 3585, horizontal on, no invert, notch 120).
`default_nettype none

module stick_to_scroll_wheel (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               tick_valid,
	output logic                               tick_ready,
	input  ssw_pkg::tick_t                     tick,
	output logic                               evt_valid,
	input  logic                               evt_ready,
	output ssw_pkg::evt_t                      evt,
	input  logic                               cfg_we,
	input  logic [ssw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssw_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ssw_pkg::*;

	cfg_t cfg_q;
	logic rec_valid, rec_ready, q_valid, q_ready;
	rec_t rec, q_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone_counts   <= 16'd655;
			cfg_q.gain_q8           <= 13'd3585;
			cfg_q.horiz_enable      <= 1'b1;
			cfg_q.invert_vertical   <= 1'b0;
			cfg_q.invert_horizontal <= 1'b0;
			cfg_q.notch_units       <= 8'd120;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEADZONE:     cfg_q.deadzone_counts   <= cfg_data;
				CFG_GAIN:         cfg_q.gain_q8           <= cfg_data[12:0];
				CFG_HORIZ_EN:     cfg_q.horiz_enable      <= cfg_data[0];
				CFG_INVERT_VERT:  cfg_q.invert_vertical   <= cfg_data[0];
				CFG_INVERT_HORIZ: cfg_q.invert_horizontal <= cfg_data[0];
				CFG_NOTCH_UNITS:  cfg_q.notch_units       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	ssw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.tick       (tick),
		.rec_valid  (rec_valid),
		.rec_ready  (rec_ready),
		.rec        (rec)
	);

	ssw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (rec_valid),
		.push_ready (rec_ready),
		.push_data  (rec),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_rec)
	);

	ssw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (q_valid),
		.rec_ready (q_ready),
		.rec       (q_rec),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt)
	);

endmodule

`default_nettype wire

// ===== src/ssw_checker.sv =====
`default_nettype none

`include "stick_to_scroll_wheel_assert.svh"

module ssw_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          evt_valid,
	input logic          evt_ready,
	input ssw_pkg::evt_t evt
);
	import ssw_pkg::*;

	`SSW_ASSERT_NXT(a_evt_hold, clk, arst_n, evt_valid && !evt_ready, evt_valid && $stable(evt))
	`SSW_ASSERT_IMP(a_last_is_sync, clk, arst_n, evt_valid && evt.last_event, evt.event_kind == KIND_SYNC && evt.event_value == 8'sd0)
	`SSW_ASSERT_IMP(a_sync_is_last, clk, arst_n, evt_valid && evt.event_kind == KIND_SYNC, evt.last_event)
	`SSW_ASSERT_IMP(a_notch_unit, clk, arst_n, evt_valid && (evt.event_kind == KIND_VNOTCH || evt.event_kind == KIND_HNOTCH), evt.event_value == 8'sd1 || evt.event_value == -8'sd1)
	`SSW_ASSERT_IMP(a_fine_range, clk, arst_n, evt_valid && (evt.event_kind == KIND_VFINE || evt.event_kind == KIND_HFINE), evt.event_value != 8'sd0 && evt.event_value <= 8'sd64 && evt.event_value >= -8'sd64)

endmodule

bind stick_to_scroll_wheel ssw_checker u_ssw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (evt_valid),
	.evt_ready (evt_ready),
	.evt       (evt)
);

`default_nettype wire
